// ===== rtl/srccalc_pkg.sv =====
// Shared constants and stage type for the sample rate converter word calculator.
`timescale 1ns / 1ps
`default_nettype none

package srccalc_pkg;

  // Channel codes; the unused fourth code behaves like the dac channel
  localparam logic [1:0] CH_SYNTH = 2'd0;
  localparam logic [1:0] CH_DAC   = 2'd1;
  localparam logic [1:0] CH_ADC   = 2'd2;

  // Field widths
  localparam int RATE_W = 16;
  localparam int WORD_W = 16;
  localparam int FREQ_W = 21;  // rate*65536/3000 stays below 2^21
  localparam int PROD_W = 22;  // frequency bits 1..21 are all that reach the outputs
  localparam int N_W    = 5;   // oversample ratio, at most 21

  // Fixed-rate frequency: floor(rate*65536/3000) = (rate * RECIP_MUL) >> RECIP_SHIFT
  localparam int          RECIP_W     = 29;
  localparam logic [28:0] RECIP_MUL   = 29'd366503876;
  localparam int          RECIP_SHIFT = 24;
  localparam int          MUL_W       = RATE_W + RECIP_W;

  // Adc divider: 48000*65536 / rate, only the low quotient bits matter
  localparam logic [31:0] DIV_DIVIDEND = 32'd3145728000;
  localparam int          QUOT_W       = 21;  // enough whenever rate >= 3000
  localparam int          REM_W        = RATE_W;
  localparam int          DIV_STEP     = 3;   // quotient bits per stage
  localparam int          DIV_STG      = QUOT_W / DIV_STEP;
  localparam logic [REM_W-1:0] DIV_INIT_REM = REM_W'(DIV_DIVIDEND >> QUOT_W);

  // Truncation word constants
  localparam logic [RATE_W-1:0] HALF_BAND_LIMIT = 16'd24000;
  localparam logic [8:0]        CLAMP_FULL      = 9'd239;
  localparam logic [8:0]        CLAMP_HALF      = 9'd119;
  localparam logic [WORD_W-1:0] HALF_BAND_BIT   = 16'h8000;

  // Pipeline: input stage, multiply/first divide stage, divide stages, n*quot stage
  localparam int NUM_STG = DIV_STG + 2;

  typedef struct packed {
    logic [1:0]        ch;
    logic [RATE_W-1:0] rate;
    logic [WORD_W-1:0] old_int;
    logic [FREQ_W-1:0] freq;
    logic [REM_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
    logic [N_W-1:0]    n;
    logic [PROD_W-1:0] prod;
  } stg_t;

endpackage

`default_nettype wire

// ===== rtl/srccalc_div_slice.sv =====
// Restoring divider slice: DIV_STEP quotient bits per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none

module srccalc_div_slice import srccalc_pkg::*; (
  input  logic [REM_W-1:0]    rem_i,
  input  logic [RATE_W-1:0]   divisor_i,
  input  logic [DIV_STEP-1:0] dvd_bits_i,  // next dividend bits, msb first
  input  logic [QUOT_W-1:0]   quot_i,
  output logic [REM_W-1:0]    rem_o,
  output logic [QUOT_W-1:0]   quot_o
);

  logic [REM_W:0]    trial;
  logic [REM_W-1:0]  rem;
  logic [QUOT_W-1:0] quot;

  // Shift in one dividend bit, subtract when it fits
  always_comb begin
    rem  = rem_i;
    quot = quot_i;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {rem, dvd_bits_i[DIV_STEP-1-i]};
      if (trial >= {1'b0, divisor_i}) begin
        rem  = REM_W'(trial - {1'b0, divisor_i});
        quot = {quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem  = trial[REM_W-1:0];
        quot = {quot[QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign rem_o  = rem;
  assign quot_o = quot;

endmodule

`default_nettype wire

// ===== rtl/src_rate_register_calculator_top.sv =====
// Top level of the sample rate converter register word calculator.
//
//   port group   dir  tdata                                  tuser
//   s_axis       in   rate[15:0] old_int_word[31:16]         channel[1:0]
//   m_axis       out  int_word[15:0] frac_word[30:16]        adc_words_valid[0]
//                     trunc_word[46:31] volume_word[59:47]   divide_error[1]
//
// Ten register stages: input, constant-reciprocal multiply with the first
// divider slice, six more divider slices (three quotient bits each, 48000*65536
// over rate), quotient times oversample ratio, output register.
// One word per cycle while m_axis_tready is high.
// Reset clears only the stage valid bits. A stall holds each full stage; empty
// stages still fill, so s_axis_tready stays high while bubbles remain.
`timescale 1ns / 1ps
`default_nettype none

module src_rate_register_calculator_top import srccalc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // rate, old_int_word
  input  logic [1:0]  s_axis_tuser,   // channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // int_word, frac_word, trunc_word, volume_word, pad
  output logic [1:0]  m_axis_tuser    // adc_words_valid, divide_error
);

  localparam int OUT_STG = NUM_STG + 1;

  stg_t stg_q [1:NUM_STG];
  stg_t stg_d [1:NUM_STG];
  logic [OUT_STG:1] v_q;
  logic [OUT_STG:1] v_in;
  logic [OUT_STG:1] rdy;

  logic [MUL_W-1:0]  freq_mul;
  logic [REM_W-1:0]  sl_rem  [DIV_STG];
  logic [QUOT_W-1:0] sl_quot [DIV_STG];
  logic [N_W-1:0]    n_raw;
  logic [N_W-1:0]    n_adj;

  logic [63:0] tdata_d, tdata_q;
  logic [1:0]  tuser_d, tuser_q;

  // Ready chain: a stage loads when empty or when the next one moves
  always_comb begin
    rdy[OUT_STG] = !v_q[OUT_STG] || m_axis_tready;
    for (int k = OUT_STG - 1; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_in[1] = s_axis_tvalid;
    for (int k = 2; k <= OUT_STG; k++) begin
      v_in[k] = v_q[k-1];
    end
  end

  assign s_axis_tready = rdy[1];

  // Fixed-rate frequency by reciprocal multiply
  assign freq_mul = MUL_W'(stg_q[1].rate) * MUL_W'(RECIP_MUL);

  // Divider slices, stage k+2 holds the result of slice k
  for (genvar s = 0; s < DIV_STG; s++) begin : g_div
    srccalc_div_slice u_slice (
      .rem_i      (stg_q[s+1].rem),
      .divisor_i  (stg_q[s+1].rate),
      .dvd_bits_i (DIV_DIVIDEND[QUOT_W-1-DIV_STEP*s -: DIV_STEP]),
      .quot_i     (stg_q[s+1].quot),
      .rem_o      (sl_rem[s]),
      .quot_o     (sl_quot[s])
    );
  end

  // Oversample ratio from the fixed-rate frequency, odd 9..15 lowered by one
  assign n_raw = stg_q[NUM_STG-1].freq[FREQ_W-1:FREQ_W-N_W];

  always_comb begin
    case (n_raw)
      5'd9, 5'd11, 5'd13, 5'd15: n_adj = n_raw - 5'd1;
      default:                   n_adj = n_raw;
    endcase
  end

  // Next values of the working stages
  always_comb begin
    stg_d[1].ch      = s_axis_tuser;
    stg_d[1].rate    = s_axis_tdata[15:0];
    stg_d[1].old_int = s_axis_tdata[31:16];
    stg_d[1].freq    = '0;
    stg_d[1].rem     = DIV_INIT_REM;
    stg_d[1].quot    = '0;
    stg_d[1].n       = '0;
    stg_d[1].prod    = '0;
    for (int k = 2; k <= NUM_STG - 1; k++) begin
      stg_d[k]      = stg_q[k-1];
      stg_d[k].rem  = sl_rem[k-2];
      stg_d[k].quot = sl_quot[k-2];
    end
    stg_d[2].freq = freq_mul[RECIP_SHIFT+FREQ_W-1:RECIP_SHIFT];
    stg_d[NUM_STG]      = stg_q[NUM_STG-1];
    stg_d[NUM_STG].n    = n_adj;
    stg_d[NUM_STG].prod = PROD_W'(stg_q[NUM_STG-1].quot * n_adj);
  end

  // Output word formatting
  logic              is_adc, rate_zero, full;
  logic [PROD_W-1:0] freq_sel;
  logic [8:0]        m9, clamp, mc, diff;
  logic [6:0]        start;
  logic [WORD_W-1:0] int_word, trunc_word;
  logic [14:0]       frac_word;
  logic [12:0]       volume_word;
  logic              adc_words_valid, divide_error;

  always_comb begin
    is_adc    = stg_q[NUM_STG].ch == CH_ADC;
    rate_zero = stg_q[NUM_STG].rate == '0;
    full      = stg_q[NUM_STG].rate >= HALF_BAND_LIMIT;
    freq_sel  = is_adc ? stg_q[NUM_STG].prod : {1'b0, stg_q[NUM_STG].freq};

    m9    = (9'(9'd21 * {4'b0, stg_q[NUM_STG].n}) - 9'd1) | 9'd1;
    clamp = full ? CLAMP_FULL : CLAMP_HALF;
    mc    = (m9 > clamp) ? clamp : m9;
    diff  = clamp - mc;
    start = diff[7:1];

    int_word    = {freq_sel[21:16], 2'b00, stg_q[NUM_STG].old_int[7:0]};
    frac_word   = freq_sel[15:1];
    trunc_word  = {start, 9'b0} | {7'b0, stg_q[NUM_STG].n, 4'b0}
                | (full ? '0 : HALF_BAND_BIT);
    volume_word = {stg_q[NUM_STG].n, 8'b0};
    adc_words_valid = 1'b0;
    divide_error    = 1'b0;

    if (!is_adc) begin
      trunc_word  = '0;
      volume_word = '0;
    end else if (rate_zero) begin
      int_word     = '0;
      frac_word    = '0;
      trunc_word   = '0;
      volume_word  = '0;
      divide_error = 1'b1;
    end else begin
      adc_words_valid = 1'b1;
    end

    tdata_d = {4'b0, volume_word, trunc_word, frac_word, int_word};
    tuser_d = {divide_error, adc_words_valid};
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= OUT_STG; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= NUM_STG; k++) begin
      if (rdy[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
    if (rdy[OUT_STG]) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  assign m_axis_tvalid = v_q[OUT_STG];
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

endmodule

`default_nettype wire
